// ===== hdl/seqm_pkg.sv =====
package seqm_pkg;

    localparam int CHAR_W     = 8;
    localparam int POS_W      = 11;
    localparam int ICOUNT_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int CHAR_SLOTS = 4;

    localparam logic [CHAR_W-1:0] CHAR_N    = 8'h4E;
    localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_DASH = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;

    localparam logic [ICOUNT_W-1:0] ICOUNT_RESET = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_POSITION = 3'd0,
        REG_COUNT_MODE     = 3'd1,
        REG_IGNORE_COUNT   = 3'd2,
        REG_IGNORE_CHAR_A  = 3'd3,
        REG_IGNORE_CHAR_B  = 3'd4,
        REG_IGNORE_CHAR_C  = 3'd5,
        REG_IGNORE_CHAR_D  = 3'd6
    } cfg_reg_t;

    localparam cfg_reg_t SLOT_REG [CHAR_SLOTS] = '{
        REG_IGNORE_CHAR_A, REG_IGNORE_CHAR_B, REG_IGNORE_CHAR_C, REG_IGNORE_CHAR_D
    };

    localparam logic [CHAR_W-1:0] SLOT_RESET [CHAR_SLOTS] = '{
        CHAR_N, CHAR_DOT, CHAR_DASH, CHAR_NONE
    };

    typedef struct packed {
        logic [POS_W-1:0]                   start_position;
        logic                               count_mode;
        logic [ICOUNT_W-1:0]                ignore_count;
        logic [CHAR_SLOTS-1:0][CHAR_W-1:0]  ignore_char;
    } cfg_t;

endpackage

// ===== hdl/sequence_mismatch_scanner.sv =====
// pipeline: an accepted item waits in the input register; its result moves into the
//   output register when that register is empty or out_ready is high
// throughput: one item per cycle when the output is not stalled; while a result waits
//   for out_ready one more item can enter the input register
// reset: rst_n clears the position and mismatch counters, the pipeline valid bits
//   and the configuration registers (start 0, index mode, ignore set N . -)
module sequence_mismatch_scanner #(
    parameter int MAX_LEN      = 1024,
    parameter int IGNORE_SLOTS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [seqm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [seqm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [seqm_pkg::CHAR_W-1:0]       ref_char,
    input  logic [seqm_pkg::CHAR_W-1:0]       read_char,
    input  logic                              seq_end,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              hit,
    output logic [seqm_pkg::POS_W-1:0]        position,
    output logic [seqm_pkg::POS_W-1:0]        total,
    output logic                              done_res
);
    import seqm_pkg::*;

    localparam int CW   = $clog2(MAX_LEN + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    cfg_t cfg;

    logic              s1_valid_reg;
    logic [CHAR_W-1:0] s1_ref_reg;
    logic [CHAR_W-1:0] s1_read_reg;
    logic              s1_end_reg;

    logic [CW-1:0]     pos_reg;
    logic [CW-1:0]     tot_reg;
    logic [CW-1:0]     tot_next;

    logic              out_valid_reg;
    logic              hit_reg;
    logic [POS_W-1:0]  position_reg;
    logic [POS_W-1:0]  total_reg;
    logic              done_reg;

    logic              differs;
    logic              advance;
    logic              mis;
    logic              emit;
    logic [CMPW-1:0]   posn;

    seqm_cfg #(
        .IGNORE_SLOTS(IGNORE_SLOTS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    seqm_match #(
        .IGNORE_SLOTS(IGNORE_SLOTS)
    ) u_match (
        .cfg       (cfg),
        .ref_char  (s1_ref_reg),
        .read_char (s1_read_reg),
        .differs   (differs)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    always_comb
    begin
        mis = differs && (CMPW'(pos_reg) >= CMPW'(cfg.start_position));
        tot_next = tot_reg;
        if (mis && (tot_reg < CW'(MAX_LEN)))
        begin
            tot_next = tot_reg + CW'(1);
        end
        // position saturates once the counter has reached the limit
        if (pos_reg >= CW'(MAX_LEN))
        begin
            posn = CMPW'(MAX_LEN);
        end
        else
        begin
            posn = CMPW'(pos_reg) + CMPW'(1);
        end
        emit = (!cfg.count_mode && mis) || s1_end_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_ref_reg  <= ref_char;
            s1_read_reg <= read_char;
            s1_end_reg  <= seq_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            tot_reg <= '0;
        end
        else if (advance)
        begin
            if (s1_end_reg)
            begin
                pos_reg <= '0;
                tot_reg <= '0;
            end
            else
            begin
                tot_reg <= tot_next;
                if (pos_reg < CW'(MAX_LEN))
                begin
                    pos_reg <= pos_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            hit_reg   <= !cfg.count_mode && mis;
            done_reg  <= s1_end_reg;
            total_reg <= CMPW'(tot_next) > CMPW'(0) ? POS_W'(CMPW'(tot_next)) : '0;
            if (!cfg.count_mode && mis)
            begin
                position_reg <= posn[POS_W-1:0];
            end
            else
            begin
                position_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign position  = position_reg;
    assign total     = total_reg;
    assign done_res  = done_reg;

endmodule

// ===== hdl/seqm_cfg.sv =====
module seqm_cfg #(
    parameter int IGNORE_SLOTS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [seqm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [seqm_pkg::CFG_DATA_W-1:0]   cfg_data,
    output seqm_pkg::cfg_t                    cfg
);
    import seqm_pkg::*;

    // only slots that can ever be active get storage
    localparam int NUM_SLOTS = (IGNORE_SLOTS < CHAR_SLOTS) ? IGNORE_SLOTS : CHAR_SLOTS;

    logic [POS_W-1:0]    start_reg;
    logic                mode_reg;
    logic [ICOUNT_W-1:0] icount_reg;
    logic [CHAR_W-1:0]   char_reg [NUM_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            mode_reg   <= 1'b0;
            icount_reg <= ICOUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_START_POSITION: start_reg  <= cfg_data[POS_W-1:0];
                REG_COUNT_MODE:     mode_reg   <= cfg_data[0];
                REG_IGNORE_COUNT:   icount_reg <= cfg_data[ICOUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                char_reg[k] <= SLOT_RESET[k];
            end
        end
        else
        begin
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                if (cfg_we && (cfg_index == SLOT_REG[k]))
                begin
                    char_reg[k] <= cfg_data[CHAR_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        cfg.start_position = start_reg;
        cfg.count_mode     = mode_reg;
        cfg.ignore_count   = icount_reg;
        for (int k = 0; k < CHAR_SLOTS; k++)
        begin
            cfg.ignore_char[k] = '0;
        end
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            cfg.ignore_char[k] = char_reg[k];
        end
    end

endmodule

// ===== hdl/seqm_match.sv =====
module seqm_match #(
    parameter int IGNORE_SLOTS = 4
) (
    input  seqm_pkg::cfg_t                cfg,
    input  logic [seqm_pkg::CHAR_W-1:0]   ref_char,
    input  logic [seqm_pkg::CHAR_W-1:0]   read_char,
    output logic                          differs
);
    import seqm_pkg::*;

    localparam int NUM_SLOTS = (IGNORE_SLOTS < CHAR_SLOTS) ? IGNORE_SLOTS : CHAR_SLOTS;

    logic ref_ignored;
    logic read_ignored;

    // slot k is active when ignore_count is above k; slots past NUM_SLOTS never are
    always_comb
    begin
        ref_ignored  = 1'b0;
        read_ignored = 1'b0;
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            if (cfg.ignore_count > ICOUNT_W'(k))
            begin
                if (cfg.ignore_char[k] == ref_char)
                begin
                    ref_ignored = 1'b1;
                end
                if (cfg.ignore_char[k] == read_char)
                begin
                    read_ignored = 1'b1;
                end
            end
        end
    end

    assign differs = (ref_char != read_char) && !ref_ignored && !read_ignored;

endmodule

// ===== hdl/seqm_checker.sv =====
module seqm_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              hit,
    input logic [seqm_pkg::POS_W-1:0]        position,
    input logic [seqm_pkg::POS_W-1:0]        total,
    input logic                              done_res
);
    import seqm_pkg::*;

    // a result waiting for the sink holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(position)
            && $stable(total) && $stable(done_res))
        else $error("result changed while stalled");

    // a reported mismatch carries a one-based position and a nonzero count
    a_hit_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> (position != '0) && (total != '0))
        else $error("mismatch result with zero position or total");

    // a result without a mismatch is an end result with no position
    a_nohit_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> done_res && (position == '0))
        else $error("non-mismatch result that is not an end result");

    // reset seen at an edge has cleared the result register by the next one
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

endmodule

bind sequence_mismatch_scanner seqm_checker u_seqm_checker (.*);
